// File: rtl/ppd_pkg.sv
package ppd_pkg;

    localparam int TIME_W      = 32;
    localparam int ID_W        = 16;
    localparam int PERIOD_W    = 16;
    localparam int MUX_ADDR_W  = 8;
    localparam int MUX_CHAN_W  = 3;
    localparam int SLOT_W      = 4;
    localparam int SLEEP_W     = 8;
    localparam int KEY_W       = MUX_ADDR_W + MUX_CHAN_W;
    localparam int CFG_COUNT_W = 5;
    localparam int IN_DATA_W   = 80;
    localparam int OUT_DATA_W  = 40;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [TIME_W-1:0] SLEEP_MIN     = 32'd5;
    localparam logic [TIME_W-1:0] SLEEP_MAX     = 32'd200;
    localparam logic [TIME_W-1:0] SLEEP_STOPPED = 32'd50;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_PASS  = 1'b1;
    localparam logic KIND_JOB   = 1'b0;
    localparam logic KIND_SLEEP = 1'b1;

    typedef enum logic
    {
        REG_JOB_COUNT = 1'b0,
        REG_RUNNING   = 1'b1
    } reg_idx_t;

    // Input payload, first field in the highest bits.
    typedef struct packed
    {
        logic [MUX_CHAN_W-1:0] mux_chan;
        logic [MUX_ADDR_W-1:0] mux_address;
        logic [PERIOD_W-1:0]   poll_period_ms;
        logic                  enabled;
        logic [ID_W-1:0]       sensor_id;
        logic [SLOT_W-1:0]     slot;
        logic [TIME_W-1:0]     now_ms;
    } in_item_t;

    // Result payload, first field in the highest bits.
    typedef struct packed
    {
        logic                  pad;
        logic [SLEEP_W-1:0]    sleep_ms;
        logic [MUX_CHAN_W-1:0] job_mux_chan;
        logic [MUX_ADDR_W-1:0] job_mux_address;
        logic [ID_W-1:0]       job_id;
        logic [SLOT_W-1:0]     job_slot;
    } out_item_t;

    typedef struct packed
    {
        logic [ID_W-1:0]       sensor_id;
        logic                  enabled;
        logic [PERIOD_W-1:0]   poll_period_ms;
        logic [MUX_ADDR_W-1:0] mux_address;
        logic [MUX_CHAN_W-1:0] mux_chan;
    } job_entry_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_SLEEP,
        ST_STOP
    } state_t;

    typedef struct packed
    {
        logic load_wr;
        logic pass_start;
        logic scan_issue;
        logic emit_read;
        logic emit_load;
        logic sleep_load;
        logic stop_load;
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic issue_more;
        logic scan_idle;
        logic list_empty;
        logic out_free;
    } ctrl_status_t;

endpackage

// File: rtl/periodic_poll_dispatcher_core.sv
// Load item: taken while idle, table written at the transfer edge, no result.
// Pass item (running): scan of n = min(job_count, MAX_JOBS) entries through the one-read
// table port, then a list pop and a dispatch for each due job, then the closing sleep;
// the next item is taken only after the sleep result is loaded.
// Stopped pass: single sleep result loaded once the output register is free.
// Reset clears control state and both registers; table contents stay undefined.
module periodic_poll_dispatcher_core #(
    parameter int MAX_JOBS = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // now_ms, slot, sensor_id, enabled, poll_period_ms, mux_address, mux_chan
    input  logic [ppd_pkg::IN_DATA_W-1:0]      s_tdata,
    // mode
    input  logic                               s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // job_slot, job_id, job_mux_address, job_mux_chan, sleep_ms, zero pad
    output logic [ppd_pkg::OUT_DATA_W-1:0]     m_tdata,
    // kind
    output logic                               m_tuser,
    output logic                               m_tlast,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ppd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ppd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ppd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import ppd_pkg::*;

    logic [CFG_COUNT_W-1:0] job_count_reg;
    logic                   running_reg;
    logic                   cfg_wr;
    reg_idx_t               cfg_idx;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // Registers are word aligned; bit 2 selects the register.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_count_reg <= '0;
            running_reg   <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_JOB_COUNT: job_count_reg <= pwdata[CFG_COUNT_W-1:0];
                REG_RUNNING:   running_reg   <= pwdata[0];
                default:       running_reg   <= running_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_JOB_COUNT: prdata = APB_DATA_W'(job_count_reg);
            REG_RUNNING:   prdata = APB_DATA_W'(running_reg);
            default:       prdata = '0;
        endcase
    end

    // Sequencer: decides transfers, scan, pop/dispatch and the closing sleep.
    ppd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (s_tuser),
        .running  (running_reg),
        .status   (status),
        .cmd      (cmd)
    );

    // Table memories, scan pipeline, sorted dispatch list and result register.
    ppd_dpath #(
        .MAX_JOBS (MAX_JOBS)
    ) u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .job_count (job_count_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// File: rtl/ppd_ctrl.sv
module ppd_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 mode,
    input  logic                 running,
    input  ppd_pkg::ctrl_status_t status,
    output ppd_pkg::ctrl_cmd_t    cmd
);
    import ppd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && mode == MODE_PASS)
                begin
                    state_next = running ? ST_SCAN : ST_STOP;
                end
            end
            ST_SCAN:
            begin
                if (!status.issue_more && status.scan_idle)
                begin
                    state_next = status.list_empty ? ST_SLEEP : ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = status.list_empty ? ST_SLEEP : ST_EMIT_RD;
                end
            end
            ST_SLEEP, ST_STOP:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready       = 1'b1;
                cmd.load_wr    = s_tvalid && mode == MODE_LOAD;
                cmd.pass_start = s_tvalid && mode == MODE_PASS && running;
            end
            ST_SCAN:
            begin
                cmd.scan_issue = status.issue_more;
            end
            ST_EMIT_RD:
            begin
                cmd.emit_read = 1'b1;
            end
            ST_EMIT_OUT:
            begin
                cmd.emit_load = status.out_free;
            end
            ST_SLEEP:
            begin
                cmd.sleep_load = status.out_free;
            end
            ST_STOP:
            begin
                cmd.stop_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_pass_enters_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pass_start |=> state_reg == ST_SCAN)
        else $error("pass start did not enter the scan");

    a_pop_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_read |=> state_reg == ST_EMIT_OUT)
        else $error("list pop not followed by dispatch");
`endif

endmodule

// File: rtl/ppd_dpath.sv
module ppd_dpath #(
    parameter int MAX_JOBS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  ppd_pkg::ctrl_cmd_t                  cmd,
    output ppd_pkg::ctrl_status_t               status,
    input  logic [ppd_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic [ppd_pkg::CFG_COUNT_W-1:0]     job_count,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ppd_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast
);
    import ppd_pkg::*;

    localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int NW = (CW > CFG_COUNT_W) ? CW : CFG_COUNT_W;

    in_item_t item;
    assign item = in_item_t'(s_tdata);

    // Load decode: slots past the table are dropped.
    logic [6:0]    slot_wide;
    logic          slot_ok;
    logic [AW-1:0] wr_addr;
    assign slot_wide = 7'(item.slot);
    assign slot_ok   = slot_wide < 7'(MAX_JOBS);
    assign wr_addr   = slot_wide[AW-1:0];

    logic [NW-1:0] count_wide;
    logic [CW-1:0] n_jobs;
    assign count_wide = NW'(job_count);
    assign n_jobs     = (count_wide > NW'(MAX_JOBS)) ? CW'(MAX_JOBS) : count_wide[CW-1:0];

    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] soonest_reg;
    logic [CW-1:0]     scan_idx_reg;

    // Table storage.
    job_entry_t        entry_mem [MAX_JOBS];
    logic [TIME_W-1:0] due_mem   [MAX_JOBS];

    job_entry_t        rd_entry_reg;
    logic [TIME_W-1:0] rd_due_reg;
    logic [AW-1:0]     rd_slot_reg;
    logic              rd_v_reg;

    logic [AW-1:0]     lst_slot_reg [MAX_JOBS];
    logic [KEY_W-1:0]  lst_key_reg  [MAX_JOBS];
    logic [CW-1:0]     lst_cnt_reg;
    logic [AW-1:0]     emit_slot_reg;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              due_we;
    logic [AW-1:0]     due_waddr;
    logic [TIME_W-1:0] due_wdata;

    assign rd_en     = cmd.scan_issue || cmd.emit_read;
    assign rd_addr   = cmd.scan_issue ? scan_idx_reg[AW-1:0] : lst_slot_reg[0];
    assign due_we    = (cmd.load_wr && slot_ok) || cmd.emit_load;
    assign due_waddr = cmd.emit_load ? emit_slot_reg : wr_addr;
    assign due_wdata = cmd.emit_load ? now_reg + TIME_W'(rd_entry_reg.poll_period_ms)
                                     : item.now_ms;

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && slot_ok)
        begin
            entry_mem[wr_addr] <= '{sensor_id:      item.sensor_id,
                                    enabled:        item.enabled,
                                    poll_period_ms: item.poll_period_ms,
                                    mux_address:    item.mux_address,
                                    mux_chan:       item.mux_chan};
        end
    end

    always_ff @(posedge clk)
    begin
        if (due_we)
        begin
            due_mem[due_waddr] <= due_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry_reg <= entry_mem[rd_addr];
            rd_due_reg   <= due_mem[rd_addr];
            rd_slot_reg  <= rd_addr;
        end
    end

    // Evaluate stage: due test and the due time the entry holds after this pass.
    logic [TIME_W-1:0] due_diff;
    logic              is_due;
    logic [TIME_W-1:0] eff_due;
    assign due_diff = now_reg - rd_due_reg;
    assign is_due   = rd_entry_reg.enabled && !due_diff[TIME_W-1];
    assign eff_due  = is_due ? now_reg + TIME_W'(rd_entry_reg.poll_period_ms) : rd_due_reg;

    logic              ev_v_reg;
    logic              ev_en_reg;
    logic              ev_due_reg;
    logic [TIME_W-1:0] ev_eff_reg;
    logic [KEY_W-1:0]  ev_key_reg;
    logic [AW-1:0]     ev_slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg <= 1'b0;
            ev_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= cmd.scan_issue;
            ev_v_reg <= rd_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_en_reg   <= rd_entry_reg.enabled;
        ev_due_reg  <= is_due;
        ev_eff_reg  <= eff_due;
        ev_key_reg  <= {rd_entry_reg.mux_address, rd_entry_reg.mux_chan};
        ev_slot_reg <= rd_slot_reg;
    end

    // Soonest-time walk, in slot order.
    logic [TIME_W-1:0] soon_diff;
    assign soon_diff = ev_eff_reg - soonest_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.pass_start)
        begin
            now_reg     <= item.now_ms;
            soonest_reg <= item.now_ms + SLEEP_MAX;
        end
        else if (ev_v_reg && ev_en_reg && soon_diff[TIME_W-1])
        begin
            soonest_reg <= ev_eff_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.pass_start)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.scan_issue)
        begin
            scan_idx_reg <= scan_idx_reg + CW'(1);
        end
    end

    // Sorted dispatch list: insert keeps equal keys in arrival (slot) order,
    // pop shifts toward the head.
    logic              ins;
    logic [MAX_JOBS-1:0] gt;
    logic [AW-1:0]     lst_slot_next [MAX_JOBS];
    logic [KEY_W-1:0]  lst_key_next  [MAX_JOBS];

    assign ins = ev_v_reg && ev_due_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_JOBS; i++)
        begin
            gt[i]            = (CW'(i) >= lst_cnt_reg) || (lst_key_reg[i] > ev_key_reg);
            lst_slot_next[i] = lst_slot_reg[i];
            lst_key_next[i]  = lst_key_reg[i];
        end
        if (ins)
        begin
            if (gt[0])
            begin
                lst_slot_next[0] = ev_slot_reg;
                lst_key_next[0]  = ev_key_reg;
            end
            for (int i = 1; i < MAX_JOBS; i++)
            begin
                if (gt[i])
                begin
                    lst_slot_next[i] = gt[i-1] ? lst_slot_reg[i-1] : ev_slot_reg;
                    lst_key_next[i]  = gt[i-1] ? lst_key_reg[i-1]  : ev_key_reg;
                end
            end
        end
        else if (cmd.emit_read)
        begin
            for (int i = 0; i < MAX_JOBS - 1; i++)
            begin
                lst_slot_next[i] = lst_slot_reg[i+1];
                lst_key_next[i]  = lst_key_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_JOBS; i++)
        begin
            lst_slot_reg[i] <= lst_slot_next[i];
            lst_key_reg[i]  <= lst_key_next[i];
        end
        if (cmd.emit_read)
        begin
            emit_slot_reg <= lst_slot_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lst_cnt_reg <= '0;
        end
        else if (cmd.pass_start)
        begin
            lst_cnt_reg <= '0;
        end
        else if (ins)
        begin
            lst_cnt_reg <= lst_cnt_reg + CW'(1);
        end
        else if (cmd.emit_read)
        begin
            lst_cnt_reg <= lst_cnt_reg - CW'(1);
        end
    end

    // Sleep clamp.
    logic [TIME_W-1:0]  wait_diff;
    logic [TIME_W-1:0]  wait_clamped;
    assign wait_diff    = soonest_reg - now_reg;
    assign wait_clamped = (wait_diff[TIME_W-1] || wait_diff < SLEEP_MIN) ? SLEEP_MIN :
                          (wait_diff > SLEEP_MAX) ? SLEEP_MAX : wait_diff;

    // Output register.
    logic      m_tvalid_reg;
    out_item_t m_data_reg;
    logic      m_kind_reg;
    logic      m_last_reg;
    logic      out_free;
    logic [6:0] emit_slot_wide;

    assign out_free       = !m_tvalid_reg || m_tready;
    assign emit_slot_wide = 7'(emit_slot_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.emit_load || cmd.sleep_load || cmd.stop_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            m_data_reg <= '{pad:             1'b0,
                            sleep_ms:        '0,
                            job_mux_chan:    rd_entry_reg.mux_chan,
                            job_mux_address: rd_entry_reg.mux_address,
                            job_id:          rd_entry_reg.sensor_id,
                            job_slot:        emit_slot_wide[SLOT_W-1:0]};
            m_kind_reg <= KIND_JOB;
            m_last_reg <= 1'b0;
        end
        else if (cmd.sleep_load || cmd.stop_load)
        begin
            m_data_reg <= '{pad:             1'b0,
                            sleep_ms:        cmd.stop_load ? SLEEP_STOPPED[SLEEP_W-1:0]
                                                           : wait_clamped[SLEEP_W-1:0],
                            job_mux_chan:    '0,
                            job_mux_address: '0,
                            job_id:          '0,
                            job_slot:        '0};
            m_kind_reg <= KIND_SLEEP;
            m_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    assign status.issue_more = scan_idx_reg < n_jobs;
    assign status.scan_idle  = !rd_v_reg && !ev_v_reg;
    assign status.list_empty = lst_cnt_reg == '0;
    assign status.out_free   = out_free;

`ifndef SYNTHESIS
    a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lst_cnt_reg <= CW'(MAX_JOBS))
        else $error("dispatch list overflow");

    a_last_on_sleep: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> m_last_reg == m_kind_reg)
        else $error("last flag does not match result kind");

    a_sleep_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && m_kind_reg == KIND_SLEEP |->
        m_data_reg.sleep_ms >= SLEEP_MIN[SLEEP_W-1:0] &&
        m_data_reg.sleep_ms <= SLEEP_MAX[SLEEP_W-1:0])
        else $error("sleep time out of range");
`endif

endmodule
